### hw/rtl/hdbm_pkg.sv
// ============================================================================
// hdbm_pkg
// Shared sizes, item codes and the control/status bundles of the HID
// descriptor button mask.
// ============================================================================
package hdbm_pkg;

    // Map and recording sizes
    localparam int MAP_BITS     = 256;
    localparam int MAX_RECORDED = 128;
    localparam int MAP_BYTES    = (MAP_BITS + 7) / 8;
    localparam int MAP_AW       = $clog2(MAP_BYTES);
    localparam int REC_W        = $clog2(MAX_RECORDED + 1);
    // 16-bit bit position plus the recorded span on top of it
    localparam int POS_W        = 17;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAT_USAGE   = 1'b1;
    localparam logic [7:0] BUTTON_PAGE_RESET = 8'h09;
    localparam logic [7:0] HAT_USAGE_RESET   = 8'h39;

    // Item prefix codes
    localparam logic [7:0] LONG_PREFIX      = 8'hFE;
    localparam logic [1:0] KIND_MAIN        = 2'd0;
    localparam logic [1:0] KIND_GLOBAL      = 2'd1;
    localparam logic [1:0] KIND_LOCAL       = 2'd2;
    localparam logic [3:0] TAG_INPUT        = 4'h8;
    localparam logic [3:0] TAG_USAGE_PAGE   = 4'h0;
    localparam logic [3:0] TAG_REPORT_SIZE  = 4'h7;
    localparam logic [3:0] TAG_REPORT_ID    = 4'h8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
    localparam logic [3:0] TAG_USAGE        = 4'h0;

    // Parse phase of the descriptor byte walker
    typedef enum logic [3:0] {
        PH_PREFIX   = 4'b0001,
        PH_SHORT    = 4'b0010,
        PH_LONGHDR  = 4'b0100,
        PH_LONGDATA = 4'b1000
    } t_phase;

    // One input beat, unpacked
    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [7:0] index;
    } t_in_beat;

    // Controller to datapath
    typedef struct packed {
        logic parse;
        logic load_out;
        logic mul;
        logic adv;
        logic mark;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic input_item;
        logic mark_done;
    } t_stat;

    // Data byte count of a short item from its size code
    function automatic logic [7:0] size_bytes(input logic [1:0] code);
        logic [7:0] res;
        res = (code == 2'd3) ? 8'd4 : {6'd0, code};
        return res;
    endfunction

endpackage

### hw/rtl/hdbm_ctrl.sv
// ============================================================================
// hdbm_ctrl
// Handshake and sequencing controller: takes beats, holds the result beat
// and steps Input items through multiply, advance and map marking.
// ============================================================================
module hdbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic          i_mode,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  hdbm_pkg::t_stat i_stat,
    output hdbm_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADV  = 4'b0100,
        S_MARK = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_tvalid, n_m_tvalid;
    logic   accept;

    // Take a report beat only when the output slot frees; descriptor beats anytime idle
    assign o_s_tready = (r_state == S_IDLE) && (!r_m_tvalid || i_m_tready || !i_mode);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_tvalid;

    // Issue datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.parse    = accept && !i_mode;
        o_cmd.load_out = accept && i_mode;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.adv      = (r_state == S_ADV);
        o_cmd.mark     = (r_state == S_MARK) && !i_stat.mark_done;
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.parse && i_stat.input_item) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_ADV;
            S_ADV:  n_state = S_MARK;
            S_MARK: begin
                if (i_stat.mark_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        n_m_tvalid = r_m_tvalid;
        if (o_cmd.load_out) begin
            n_m_tvalid = 1'b1;
        end else if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

endmodule

### hw/rtl/hdbm_datapath.sv
// ============================================================================
// hdbm_datapath
// Descriptor parse state, bit map, marking unit and report byte masking.
// ============================================================================
module hdbm_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [hdbm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [7:0]                        i_cfg_wdata,
    input  hdbm_pkg::t_in_beat                i_beat,
    input  hdbm_pkg::t_cmd                    i_cmd,
    output hdbm_pkg::t_stat                   o_stat,
    output logic [7:0]                        o_masked_byte,
    output logic [7:0]                        o_out_index
);

    // Configuration
    logic [7:0] r_btn_page;
    logic [7:0] r_hat_usage;

    // Parse state
    hdbm_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [7:0]  r_left, n_left, cur_left;
    logic [7:0]  r_prefix, n_prefix, cur_prefix;
    logic [7:0]  r_value, n_value, cur_value;
    logic [7:0]  r_size, n_size, cur_size;
    logic [7:0]  r_count, n_count, cur_count;
    logic [15:0] r_bit_pos, n_bit_pos, cur_bit_pos;
    logic [7:0]  r_rid, n_rid, cur_rid;
    logic        r_marked, n_marked, cur_marked;
    logic        r_stopped, n_stopped, cur_stopped;
    logic [hdbm_pkg::REC_W-1:0] r_recorded, cur_recorded;
    logic        r_mask_en;
    logic [7:0]  r_map [hdbm_pkg::MAP_BYTES];

    // Item dispatch
    logic        item_go;
    logic [7:0]  go_prefix;
    logic [7:0]  go_val;
    logic [7:0]  sz;
    logic [7:0]  left_dec;
    logic        input_item;

    // Marking unit
    logic [15:0]                r_total;
    logic [hdbm_pkg::POS_W-1:0] r_mk_pos;
    logic [hdbm_pkg::REC_W-1:0] r_mk_left;
    logic [hdbm_pkg::REC_W-1:0] rec_rem;
    logic [hdbm_pkg::REC_W-1:0] rec_take;
    logic [2:0]                 mk_bit;
    logic [3:0]                 mk_room;
    logic [3:0]                 mk_num;
    logic [8:0]                 mk_low;
    logic [15:0]                mk_shift;
    logic                       mk_in_map;

    // Report masking
    logic [7:0] r_out_byte, r_out_idx;
    logic [7:0] idx_m1;
    logic [7:0] mask_byte;
    logic [7:0] res_byte;

    // Start from cleared state on the first descriptor byte
    always_comb begin
        cur_phase    = i_beat.first ? hdbm_pkg::PH_PREFIX : r_phase;
        cur_left     = i_beat.first ? 8'd0  : r_left;
        cur_prefix   = i_beat.first ? 8'd0  : r_prefix;
        cur_value    = i_beat.first ? 8'd0  : r_value;
        cur_size     = i_beat.first ? 8'd0  : r_size;
        cur_count    = i_beat.first ? 8'd0  : r_count;
        cur_bit_pos  = i_beat.first ? 16'd0 : r_bit_pos;
        cur_rid      = i_beat.first ? 8'd0  : r_rid;
        cur_marked   = i_beat.first ? 1'b0  : r_marked;
        cur_stopped  = i_beat.first ? 1'b0  : r_stopped;
        cur_recorded = i_beat.first ? '0    : r_recorded;
    end

    // Walk one descriptor byte
    always_comb begin
        n_phase   = cur_phase;
        n_left    = cur_left;
        n_prefix  = cur_prefix;
        n_value   = cur_value;
        item_go   = 1'b0;
        go_prefix = cur_prefix;
        go_val    = 8'd0;
        sz        = 8'd0;
        left_dec  = 8'd0;
        if (!cur_stopped) begin
            case (cur_phase)
                hdbm_pkg::PH_PREFIX: begin
                    if (i_beat.data == hdbm_pkg::LONG_PREFIX) begin
                        n_phase = hdbm_pkg::PH_LONGHDR;
                        n_left  = 8'd2;
                    end else begin
                        sz       = hdbm_pkg::size_bytes(i_beat.data[1:0]);
                        n_prefix = i_beat.data;
                        n_value  = 8'd0;
                        if (sz == 8'd0 || i_beat.last) begin
                            item_go   = 1'b1;
                            go_prefix = i_beat.data;
                            go_val    = 8'd0;
                            n_phase   = hdbm_pkg::PH_PREFIX;
                            n_left    = 8'd0;
                        end else begin
                            n_phase = hdbm_pkg::PH_SHORT;
                            n_left  = sz;
                        end
                    end
                end
                hdbm_pkg::PH_SHORT: begin
                    sz = hdbm_pkg::size_bytes(cur_prefix[1:0]);
                    // keep only the low data byte
                    if (cur_left == sz) begin
                        n_value = i_beat.data;
                    end
                    left_dec = (cur_left != 8'd0) ? cur_left - 8'd1 : 8'd0;
                    n_left   = left_dec;
                    if (left_dec == 8'd0 || i_beat.last) begin
                        item_go   = 1'b1;
                        go_prefix = cur_prefix;
                        go_val    = n_value;
                        n_phase   = hdbm_pkg::PH_PREFIX;
                        n_left    = 8'd0;
                    end
                end
                hdbm_pkg::PH_LONGHDR: begin
                    if (cur_left == 8'd2) begin
                        n_value = i_beat.data;
                        n_left  = 8'd1;
                    end else begin
                        n_left  = cur_value;
                        n_phase = (cur_value == 8'd0) ? hdbm_pkg::PH_PREFIX
                                                      : hdbm_pkg::PH_LONGDATA;
                    end
                end
                default: begin
                    // skip long item data
                    left_dec = (cur_left != 8'd0) ? cur_left - 8'd1 : 8'd0;
                    n_left   = left_dec;
                    if (left_dec == 8'd0) begin
                        n_phase = hdbm_pkg::PH_PREFIX;
                    end
                end
            endcase
        end
        // last byte always leaves the walker at a prefix
        if (i_beat.last) begin
            n_phase = hdbm_pkg::PH_PREFIX;
            n_left  = 8'd0;
        end
    end

    // Act on a completed item
    always_comb begin
        n_size     = cur_size;
        n_count    = cur_count;
        n_bit_pos  = cur_bit_pos;
        n_rid      = cur_rid;
        n_marked   = cur_marked;
        n_stopped  = cur_stopped;
        input_item = 1'b0;
        if (item_go) begin
            case (go_prefix[3:2])
                hdbm_pkg::KIND_MAIN: begin
                    if (go_prefix[7:4] == hdbm_pkg::TAG_INPUT) begin
                        input_item = 1'b1;
                    end
                end
                hdbm_pkg::KIND_GLOBAL: begin
                    case (go_prefix[7:4])
                        hdbm_pkg::TAG_USAGE_PAGE: begin
                            if (go_val == r_btn_page) begin
                                n_marked = 1'b1;
                            end
                        end
                        hdbm_pkg::TAG_REPORT_SIZE:  n_size  = go_val;
                        hdbm_pkg::TAG_REPORT_COUNT: n_count = go_val;
                        hdbm_pkg::TAG_REPORT_ID: begin
                            if (cur_rid != 8'd0) begin
                                n_stopped = 1'b1;
                            end else begin
                                n_rid     = go_val;
                                n_bit_pos = 16'd0;
                            end
                        end
                        default: ;
                    endcase
                end
                hdbm_pkg::KIND_LOCAL: begin
                    if (go_prefix[7:4] == hdbm_pkg::TAG_USAGE && go_val == r_hat_usage) begin
                        n_marked = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Bits the next Input item may still record under the cap
    assign rec_rem  = hdbm_pkg::REC_W'(hdbm_pkg::MAX_RECORDED) - r_recorded;
    assign rec_take = (r_total < 16'(rec_rem)) ? r_total[hdbm_pkg::REC_W-1:0] : rec_rem;

    // Bit run that fits in the current map byte
    assign mk_bit    = r_mk_pos[2:0];
    assign mk_room   = 4'd8 - {1'b0, mk_bit};
    assign mk_num    = (r_mk_left < hdbm_pkg::REC_W'(mk_room)) ? 4'(r_mk_left) : mk_room;
    assign mk_low    = (9'd1 << mk_num) - 9'd1;
    assign mk_shift  = {7'd0, mk_low} << mk_bit;
    assign mk_in_map = r_mk_pos < hdbm_pkg::POS_W'(hdbm_pkg::MAP_BITS);

    assign o_stat.input_item = input_item;
    assign o_stat.mark_done  = (r_mk_left == '0) || !mk_in_map;

    // Pick the map byte for a report byte, one byte later after a report ID
    assign idx_m1 = i_beat.index - 8'd1;
    always_comb begin
        mask_byte = 8'd0;
        if (r_rid != 8'd0) begin
            if (i_beat.index != 8'd0
                && {1'b0, i_beat.index} < 9'(hdbm_pkg::MAP_BYTES)
                && {1'b0, i_beat.index, 3'b000} < 12'(hdbm_pkg::MAP_BITS)) begin
                mask_byte = r_map[idx_m1[hdbm_pkg::MAP_AW-1:0]];
            end
        end else if ({1'b0, i_beat.index} < 9'(hdbm_pkg::MAP_BYTES)) begin
            mask_byte = r_map[i_beat.index[hdbm_pkg::MAP_AW-1:0]];
        end
        res_byte = r_mask_en ? (i_beat.data & mask_byte) : i_beat.data;
    end

    assign o_masked_byte = r_out_byte;
    assign o_out_index   = r_out_idx;

    // Configuration, parse and marking registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_page  <= hdbm_pkg::BUTTON_PAGE_RESET;
            r_hat_usage <= hdbm_pkg::HAT_USAGE_RESET;
            r_phase     <= hdbm_pkg::PH_PREFIX;
            r_left      <= 8'd0;
            r_prefix    <= 8'd0;
            r_value     <= 8'd0;
            r_size      <= 8'd0;
            r_count     <= 8'd0;
            r_bit_pos   <= 16'd0;
            r_rid       <= 8'd0;
            r_marked    <= 1'b0;
            r_stopped   <= 1'b0;
            r_recorded  <= '0;
            r_mask_en   <= 1'b0;
            r_mk_left   <= '0;
            for (int i = 0; i < hdbm_pkg::MAP_BYTES; i++) begin
                r_map[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    hdbm_pkg::CFG_BUTTON_PAGE: r_btn_page  <= i_cfg_wdata;
                    hdbm_pkg::CFG_HAT_USAGE:   r_hat_usage <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.parse) begin
                r_phase    <= n_phase;
                r_left     <= n_left;
                r_prefix   <= n_prefix;
                r_value    <= n_value;
                r_size     <= n_size;
                r_count    <= n_count;
                r_bit_pos  <= n_bit_pos;
                r_rid      <= n_rid;
                r_marked   <= n_marked;
                r_stopped  <= n_stopped;
                r_recorded <= cur_recorded;
                if (i_beat.first) begin
                    for (int i = 0; i < hdbm_pkg::MAP_BYTES; i++) begin
                        r_map[i] <= 8'd0;
                    end
                end
                if (i_beat.last) begin
                    r_mask_en <= 1'b1;
                end
            end
            // Advance the bit position and set up the marking run
            if (i_cmd.adv) begin
                r_bit_pos <= r_bit_pos + r_total;
                r_marked  <= 1'b0;
                if (r_marked) begin
                    r_mk_left  <= rec_take;
                    r_recorded <= r_recorded + rec_take;
                end else begin
                    r_mk_left <= '0;
                end
            end
            // Mark one map byte per cycle
            if (i_cmd.mark) begin
                r_map[r_mk_pos[3 +: hdbm_pkg::MAP_AW]] <=
                    r_map[r_mk_pos[3 +: hdbm_pkg::MAP_AW]] | mk_shift[7:0];
                r_mk_left <= r_mk_left - hdbm_pkg::REC_W'(mk_num);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_total <= 16'(r_count) * 16'(r_size);
        end
        if (i_cmd.adv) begin
            r_mk_pos <= {1'b0, r_bit_pos};
        end else if (i_cmd.mark) begin
            r_mk_pos <= r_mk_pos + hdbm_pkg::POS_W'(mk_num);
        end
        if (i_cmd.load_out) begin
            r_out_byte <= res_byte;
            r_out_idx  <= i_beat.index;
        end
    end

endmodule

### hw/rtl/hid_descriptor_button_mask.sv
// ============================================================================
// hid_descriptor_button_mask
// Parses a HID report descriptor into a bit map of button and hat switch
// fields, then masks report bytes with that map.
// ============================================================================
// Channel   Dir  Handshake               Payload
// s (in)    in   i_s_tvalid/o_s_tready   tdata, tlast = last_byte, tuser
// m (out)   out  o_m_tvalid/i_m_tready   tdata
// cfg       in   i_cfg_wen               i_cfg_idx, i_cfg_wdata
//
// One report byte can be accepted every cycle while the sequencer is idle and
// the output beat drains. After an Input item byte the sequencer steps through
// multiply, advance, one marking step per map byte its recorded bits touch and
// a closing step before it takes the next beat. Descriptor beats are taken
// while a result beat waits; report beats wait for the output register to
// free. Reset is synchronous and clears the map flops.
// ============================================================================
module hid_descriptor_button_mask (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [hdbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [15:0]                    i_s_tdata,  // data_byte[7:0], byte_index[15:8]
    input  logic                           i_s_tlast,
    input  logic [1:0]                     i_s_tuser,  // mode[0], first_byte[1]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [15:0]                    o_m_tdata   // masked_byte[7:0], out_index[15:8]
);

    hdbm_pkg::t_in_beat beat;
    hdbm_pkg::t_cmd     cmd;
    hdbm_pkg::t_stat    stat;
    logic [7:0]         masked_byte;
    logic [7:0]         out_index;

    // Unpack the input beat
    assign beat.mode  = i_s_tuser[0];
    assign beat.data  = i_s_tdata[7:0];
    assign beat.first = i_s_tuser[1];
    assign beat.last  = i_s_tlast;
    assign beat.index = i_s_tdata[15:8];

    assign o_m_tdata = {out_index, masked_byte};

    hdbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_mode     (beat.mode),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hdbm_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_beat        (beat),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_masked_byte (masked_byte),
        .o_out_index   (out_index)
    );

endmodule

### tb/hid_descriptor_button_mask_tb.sv
// ----------------------------------------------------------------------------
// hid_descriptor_button_mask_tb
// Feeds HID report descriptors and report bytes into the button mask block.
// An in-bench model parses the same descriptor bytes, builds its own bit map
// and predicts every masked report beat. Each result beat is compared field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hid_descriptor_button_mask_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1750;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_GAP       = 17;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] masked;
        logic [7:0] index;
    } t_mask_beat;

    // Model of the parser and the mask, plus the queue of predicted beats
    class report_mask_tracker;
        logic [7:0]       button_page;
        logic [7:0]       hat_usage;
        hdbm_pkg::t_phase phase;
        logic [7:0]       left_cnt;
        logic [7:0]       prefix;
        logic [7:0]       value;
        logic [7:0]       fsize;
        logic [7:0]       fcount;
        logic [15:0]      bitpos;
        logic [7:0]       rep_id;
        bit               marked;
        bit               stopped;
        int unsigned      recorded;
        logic [7:0]       bit_map [hdbm_pkg::MAP_BYTES];
        bit               masking;
        t_mask_beat       expected_beats [$];
        int               errors;

        function new();
            button_page = hdbm_pkg::BUTTON_PAGE_RESET;
            hat_usage   = hdbm_pkg::HAT_USAGE_RESET;
            masking     = 1'b0;
            errors      = 0;
            clear_parse();
        endfunction

        function void set_reg(logic [hdbm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == hdbm_pkg::CFG_BUTTON_PAGE) button_page = val;
            else if (idx == hdbm_pkg::CFG_HAT_USAGE) hat_usage = val;
        endfunction

        function void clear_parse();
            phase    = hdbm_pkg::PH_PREFIX;
            left_cnt = '0;
            prefix   = '0;
            value    = '0;
            fsize    = '0;
            fcount   = '0;
            bitpos   = '0;
            rep_id   = '0;
            marked   = 1'b0;
            stopped  = 1'b0;
            recorded = 0;
            foreach (bit_map[k]) bit_map[k] = '0;
        endfunction

        function logic [7:0] data_len(logic [1:0] code);
            return (code == 2'd3) ? 8'd4 : {6'd0, code};
        endfunction

        // Set the bits of one Input field range, up to the recording cap
        function void mark_bits();
            int unsigned total;
            int unsigned b;
            int unsigned pos;
            total = 32'(fcount) * 32'(fsize);
            for (b = 0; b < total && recorded < hdbm_pkg::MAX_RECORDED; b++) begin
                pos = 32'(bitpos) + b;
                if (pos < hdbm_pkg::MAP_BITS) bit_map[pos >> 3][pos[2:0]] = 1'b1;
                recorded++;
            end
        endfunction

        // Act on one complete (or cut short) short item
        function void run_item(logic [7:0] pfx, logic [7:0] val);
            logic [1:0]  kind;
            logic [3:0]  tag;
            int unsigned total;
            kind  = pfx[3:2];
            tag   = pfx[7:4];
            total = 32'(fcount) * 32'(fsize);
            if (kind == hdbm_pkg::KIND_MAIN) begin
                if (tag == hdbm_pkg::TAG_INPUT) begin
                    if (marked) begin
                        mark_bits();
                        marked = 1'b0;
                    end
                    bitpos = bitpos + 16'(total);
                end
            end else if (kind == hdbm_pkg::KIND_GLOBAL) begin
                if (tag == hdbm_pkg::TAG_USAGE_PAGE) begin
                    if (val == button_page) marked = 1'b1;
                end else if (tag == hdbm_pkg::TAG_REPORT_SIZE) begin
                    fsize = val;
                end else if (tag == hdbm_pkg::TAG_REPORT_ID) begin
                    if (rep_id != 8'd0) begin
                        stopped = 1'b1;
                    end else begin
                        rep_id = val;
                        bitpos = '0;
                    end
                end else if (tag == hdbm_pkg::TAG_REPORT_COUNT) begin
                    fcount = val;
                end
            end else if (kind == hdbm_pkg::KIND_LOCAL) begin
                if (tag == hdbm_pkg::TAG_USAGE && val == hat_usage) marked = 1'b1;
            end
        endfunction

        // Advance the descriptor walker by one byte
        function void walk(logic [7:0] d, bit last);
            logic [7:0] sz;
            if (stopped) return;
            case (phase)
                hdbm_pkg::PH_PREFIX: begin
                    if (d == hdbm_pkg::LONG_PREFIX) begin
                        phase    = hdbm_pkg::PH_LONGHDR;
                        left_cnt = 8'd2;
                    end else begin
                        sz     = data_len(d[1:0]);
                        prefix = d;
                        value  = '0;
                        if (sz == 8'd0 || last) begin
                            run_item(d, 8'd0);
                            phase    = hdbm_pkg::PH_PREFIX;
                            left_cnt = '0;
                        end else begin
                            phase    = hdbm_pkg::PH_SHORT;
                            left_cnt = sz;
                        end
                    end
                end
                hdbm_pkg::PH_SHORT: begin
                    sz = data_len(prefix[1:0]);
                    if (left_cnt == sz) value = d;
                    if (left_cnt > 8'd0) left_cnt--;
                    if (left_cnt == 8'd0 || last) begin
                        run_item(prefix, value);
                        phase    = hdbm_pkg::PH_PREFIX;
                        left_cnt = '0;
                    end
                end
                hdbm_pkg::PH_LONGHDR: begin
                    if (left_cnt == 8'd2) begin
                        value    = d;
                        left_cnt = 8'd1;
                    end else begin
                        left_cnt = value;
                        phase    = (left_cnt == 8'd0) ? hdbm_pkg::PH_PREFIX
                                                      : hdbm_pkg::PH_LONGDATA;
                    end
                end
                default: begin
                    if (left_cnt > 8'd0) left_cnt--;
                    if (left_cnt == 8'd0) phase = hdbm_pkg::PH_PREFIX;
                end
            endcase
        endfunction

        // Note one accepted input beat; report beats queue a prediction
        function void note_beat(bit mode, logic [7:0] d, bit first, bit last,
                                logic [7:0] idx);
            logic [7:0] m;
            t_mask_beat exp_beat;
            if (!mode) begin
                if (first) clear_parse();
                walk(d, last);
                if (last) begin
                    masking  = 1'b1;
                    phase    = hdbm_pkg::PH_PREFIX;
                    left_cnt = '0;
                end
            end else begin
                exp_beat.masked = d;
                exp_beat.index  = idx;
                if (masking) begin
                    m = 8'd0;
                    if (rep_id != 8'd0) begin
                        if (idx >= 8'd1 && idx < hdbm_pkg::MAP_BYTES
                            && 32'(idx) * 8 < hdbm_pkg::MAP_BITS)
                            m = bit_map[idx - 8'd1];
                    end else if (idx < hdbm_pkg::MAP_BYTES) begin
                        m = bit_map[idx];
                    end
                    exp_beat.masked = d & m;
                end
                expected_beats.push_back(exp_beat);
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_beat(logic [15:0] tdata);
            t_mask_beat exp_beat;
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: byte %02h index %02h",
                             tdata[7:0], tdata[15:8]);
            end else begin
                exp_beat = expected_beats.pop_front();
                if (tdata[7:0] !== exp_beat.masked || tdata[15:8] !== exp_beat.index) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: byte exp %02h got %02h, index exp %02h got %02h",
                                 exp_beat.masked, tdata[7:0], exp_beat.index, tdata[15:8]);
                end
            end
        endfunction
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_wen   = 1'b0;
    logic [hdbm_pkg::CFG_IDX_W-1:0] i_cfg_idx   = hdbm_pkg::CFG_BUTTON_PAGE;
    logic [7:0]                     i_cfg_wdata = 8'd0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [15:0]                    i_s_tdata   = 16'd0;  // data_byte[7:0], byte_index[15:8]
    logic                           i_s_tlast   = 1'b0;
    logic [1:0]                     i_s_tuser   = 2'd0;   // mode[0], first_byte[1]
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [15:0]                    o_m_tdata;            // masked_byte[7:0], out_index[15:8]

    report_mask_tracker tracker;
    logic [7:0] desc_q [$];
    int  items_sent  = 0;
    int  cycle_count = 0;
    int  rx_wait     = 0;
    bit  tx_burst    = 1'b0;
    bit  rx_burst    = 1'b0;

    hid_descriptor_button_mask uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Take result beats with random stalls, sometimes none for a stretch
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                tracker.check_beat(o_m_tdata);
                if ($urandom_range(0, 24) == 0) rx_burst = ~rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_m_tready <= (rx_wait == 0);
        end
    end

    // Drive one input beat after a random gap and hold it until taken
    task automatic send_beat(input bit mode, input logic [7:0] d, input bit first,
                             input bit last, input logic [7:0] idx);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {idx, d};
        i_s_tlast  <= last;
        i_s_tuser  <= {first, mode};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        tracker.note_beat(mode, d, first, last, idx);
    endtask

    // Hold off until every result is back and the marking unit has settled
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] page, input logic [7:0] hat);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= hdbm_pkg::CFG_BUTTON_PAGE;
        i_cfg_wdata <= page;
        @(posedge i_clk);
        tracker.set_reg(hdbm_pkg::CFG_BUTTON_PAGE, page);
        i_cfg_idx   <= hdbm_pkg::CFG_HAT_USAGE;
        i_cfg_wdata <= hat;
        @(posedge i_clk);
        tracker.set_reg(hdbm_pkg::CFG_HAT_USAGE, hat);
        i_cfg_wen   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_reg_value(input logic [7:0] reset_val);
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return reset_val;
            default: return 8'($urandom);
        endcase
    endfunction

    // Append a short item: prefix, low data byte, random upper bytes
    function automatic void push_item(input logic [7:0] pfx, input logic [7:0] val);
        int n;
        n = (pfx[1:0] == 2'd3) ? 4 : int'(pfx[1:0]);
        desc_q.push_back(pfx);
        for (int k = 0; k < n; k++) desc_q.push_back((k == 0) ? val : 8'($urandom));
    endfunction

    // Build a random descriptor, mostly well-formed items with some noise
    function automatic void build_descriptor();
        int n_items;
        int pick;
        int n;
        logic [7:0] val;
        desc_q.delete();
        if ($urandom_range(0, 1) == 0) begin
            push_item({hdbm_pkg::TAG_USAGE_PAGE, hdbm_pkg::KIND_GLOBAL, 2'd1},
                      tracker.button_page);
            push_item({hdbm_pkg::TAG_REPORT_SIZE, hdbm_pkg::KIND_GLOBAL, 2'd1},
                      8'($urandom_range(1, 8)));
            push_item({hdbm_pkg::TAG_REPORT_COUNT, hdbm_pkg::KIND_GLOBAL, 2'd1},
                      8'($urandom_range(1, 16)));
            push_item({hdbm_pkg::TAG_INPUT, hdbm_pkg::KIND_MAIN, 2'd1}, 8'h02);
        end
        n_items = $urandom_range(2, 14);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 19);
            if (pick <= 2) begin
                val = $urandom_range(0, 1) ? tracker.button_page : 8'($urandom);
                push_item({hdbm_pkg::TAG_USAGE_PAGE, hdbm_pkg::KIND_GLOBAL,
                           2'($urandom_range(1, 3))}, val);
            end else if (pick <= 4) begin
                val = $urandom_range(0, 1) ? tracker.hat_usage : 8'($urandom);
                push_item({hdbm_pkg::TAG_USAGE, hdbm_pkg::KIND_LOCAL,
                           2'($urandom_range(1, 3))}, val);
            end else if (pick <= 7) begin
                val = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 8)) : 8'($urandom);
                push_item({hdbm_pkg::TAG_REPORT_SIZE, hdbm_pkg::KIND_GLOBAL, 2'd1}, val);
            end else if (pick <= 10) begin
                val = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 16)) : 8'($urandom);
                push_item({hdbm_pkg::TAG_REPORT_COUNT, hdbm_pkg::KIND_GLOBAL, 2'd1}, val);
            end else if (pick == 11) begin
                val = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
                push_item({hdbm_pkg::TAG_REPORT_ID, hdbm_pkg::KIND_GLOBAL,
                           2'($urandom_range(1, 3))}, val);
            end else if (pick <= 15) begin
                push_item({hdbm_pkg::TAG_INPUT, hdbm_pkg::KIND_MAIN,
                           2'($urandom_range(0, 3))}, 8'($urandom));
            end else if (pick == 16) begin
                n = $urandom_range(0, 4);
                desc_q.push_back(hdbm_pkg::LONG_PREFIX);
                desc_q.push_back(8'(n));
                desc_q.push_back(8'($urandom));
                for (int j = 0; j < n; j++) desc_q.push_back(8'($urandom));
            end else if (pick <= 18) begin
                push_item(8'($urandom), 8'($urandom));
            end else begin
                desc_q.push_back(8'($urandom));
            end
        end
        // cut the last item short now and then
        if ($urandom_range(0, 7) == 0 && desc_q.size() > 1) void'(desc_q.pop_back());
    endfunction

    // Send desc_q as one descriptor; optionally slip report beats in between
    task automatic send_descriptor(input bit mixed);
        for (int k = 0; k < desc_q.size(); k++) begin
            if (mixed && $urandom_range(0, 29) == 0)
                send_beat(1'b1, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
            send_beat(1'b0, desc_q[k], k == 0, k == desc_q.size() - 1, 8'($urandom));
        end
    endtask

    task automatic send_reports();
        int n;
        int start;
        bit in_order;
        logic [7:0] d;
        n        = $urandom_range(1, 24);
        in_order = $urandom_range(0, 1);
        start    = $urandom_range(0, 20);
        for (int k = 0; k < n; k++) begin
            d = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
            send_beat(1'b1, d, 1'($urandom), 1'($urandom),
                      in_order ? 8'(start + k) : 8'($urandom));
        end
    endtask

    initial begin
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Masking is off before any descriptor: pass through
        send_beat(1'b1, 8'hFF, 1'b0, 1'b0, 8'h00);

        // Button page, 12 one-bit fields; Input cut short by the last byte
        desc_q = {8'h05, 8'h09, 8'h75, 8'h01, 8'h95, 8'h0C, 8'h81};
        send_descriptor(1'b0);
        send_beat(1'b1, 8'hFF, 1'b0, 1'b0, 8'h01);

        wait_idle();
        write_regs(8'h00, 8'hFF);

        // Report ID, hat usage, long item, then a second Report ID stops parsing
        desc_q = {8'h85, 8'h03, 8'h09, 8'hFF, 8'h75, 8'h08, 8'h95, 8'h02,
                  8'hFE, 8'h00, 8'h5A, 8'h81, 8'h02, 8'h85};
        send_descriptor(1'b0);
        send_beat(1'b1, 8'hFF, 1'b0, 1'b0, 8'h00);
        send_beat(1'b1, 8'hFF, 1'b0, 1'b0, 8'h02);
        send_beat(1'b1, 8'hFF, 1'b0, 1'b0, 8'hFF);

        wait_idle();
        write_regs(hdbm_pkg::BUTTON_PAGE_RESET, hdbm_pkg::HAT_USAGE_RESET);

        // Random descriptors, reports, noise and register changes
        while (items_sent < ITEM_TARGET) begin
            tx_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0) begin
                wait_idle();
                write_regs(pick_reg_value(hdbm_pkg::BUTTON_PAGE_RESET),
                           pick_reg_value(hdbm_pkg::HAT_USAGE_RESET));
            end
            build_descriptor();
            send_descriptor(1'b1);
            send_reports();
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_beat(1'b0, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 9) == 0) wait_idle();
        end

        wait_idle();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
